/* src/dqs_pkg.sv */
package dqs_pkg;

   // Storage geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int WORD_BITS   = 32;
   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   // Fixed widths of the beat fields.
   localparam int OP_BITS     = 3;
   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 2;
   localparam int POS_BITS    = 4;
   localparam int OCC_BITS    = 5;

   typedef logic [PTR_BITS-1:0]         ptr_type;
   typedef logic [CNT_BITS-1:0]         cnt_type;
   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_FIND       = 3'd4
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_RESP
   } state_type;

   // Write request into the word store.
   typedef struct packed {
      logic     en;
      ptr_type  addr;
      word_type data;
   } wr_req_type;

   // Read request into the word store.
   typedef struct packed {
      logic    en;
      ptr_type addr;
   } rd_req_type;

   localparam logic [PTR_BITS:0] DEPTH_EXT = (PTR_BITS + 1)'(QUEUE_DEPTH);
   localparam ptr_type           LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);

   // Slot at a given offset from a base slot, wrapped around the store.
   function automatic ptr_type slot_add(input ptr_type base, input ptr_type offset);
      logic [PTR_BITS:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= DEPTH_EXT) begin
         sum = sum - DEPTH_EXT;
      end
      return sum[PTR_BITS-1:0];
   endfunction

   // Next slot, wrapped.
   function automatic ptr_type slot_inc(input ptr_type slot);
      return (slot == LAST_SLOT) ? '0 : slot + PTR_BITS'(1);
   endfunction

   // Previous slot, wrapped.
   function automatic ptr_type slot_dec(input ptr_type slot);
      return (slot == '0) ? LAST_SLOT : slot - PTR_BITS'(1);
   endfunction

endpackage

/* src/dqs_req_if.sv */
interface dqs_req_if import dqs_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [OP_BITS-1:0]           operation;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, operation, value, input ready);
   modport sink   (input valid, operation, value, output ready);
endinterface

/* src/dqs_rsp_if.sv */
interface dqs_rsp_if import dqs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [POS_BITS-1:0]    found_position;
   logic [OCC_BITS-1:0]    occupancy;

   modport source (output valid, status, found_position, occupancy, input ready);
   modport sink   (input valid, status, found_position, occupancy, output ready);
endinterface

/* src/dqs_store.sv */
module dqs_store import dqs_pkg::*; (
   input  logic       clock,
   input  wr_req_type wr_req,
   input  rd_req_type rd_req,
   output word_type   rd_data
);

   word_type mem [QUEUE_DEPTH];
   word_type rd_data_ff;

   // One write port; entries hold nothing meaningful until pushed.
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
   end

   // One registered read port.
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_data_ff <= mem[rd_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/double_ended_queue_with_search.sv */
// Bounded double-ended queue of signed words with a search by key. Each request beat
// carries one operation (push back, push front, pop back, pop front or find) and gives
// exactly one response beat with a status, the position of a found word and the number
// of words held afterwards. Requests are taken one at a time: a push or pop updates the
// queue as its request is taken and then gives its response, and a find scans the held
// words, read one per cycle through the single read port of the word store and checked
// by one shared comparator, starting at the front and stopping at the first match. The
// request side is ready again in the cycle after the response beat is taken. Reset clears
// the front pointer and the count at once and needs no clearing pass; unused operation
// codes leave the queue alone and report ok.
module double_ended_queue_with_search import dqs_pkg::*; (
   input logic    clock,
   input logic    reset,
   dqs_req_if.sink   req_bus,
   dqs_rsp_if.source rsp_bus
);

   state_type  state_ff, state_in;
   ptr_type    front_ff, front_in;
   cnt_type    count_ff, count_in;
   word_type   key_ff, key_in;
   ptr_type    rd_addr_ff, rd_addr_in;
   cnt_type    rd_idx_ff, rd_idx_in;
   logic       cmp_vld_ff, cmp_vld_in;
   ptr_type    cmp_idx_ff, cmp_idx_in;
   status_type status_ff, status_in;
   ptr_type    pos_ff, pos_in;

   wr_req_type wr_req;
   rd_req_type rd_req;
   word_type   rd_data;
   word_type   req_word;
   logic       req_fire;
   logic       is_full;
   logic       is_empty;

   dqs_store u_store (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_req  (rd_req),
      .rd_data (rd_data)
   );

   // The beat value is kept as a word of the store width, sign-extended.
   assign req_word = word_type'(req_bus.value);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign is_full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= STATE_IDLE;
         front_ff   <= '0;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         front_ff   <= front_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      rd_addr_ff <= rd_addr_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      status_ff  <= status_in;
      pos_ff     <= pos_in;
   end

   // Sequencer: operation decode, search loop and response.
   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      key_in      = key_ff;
      rd_addr_in  = rd_addr_ff;
      rd_idx_in   = rd_idx_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      status_in   = status_ff;
      pos_in      = pos_ff;
      wr_req      = '{en: 1'b0, addr: slot_add(front_ff, count_ff[PTR_BITS-1:0]),
                      data: req_word};
      rd_req      = '{en: 1'b0, addr: rd_addr_ff};
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;

      unique case (state_ff)
         STATE_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_fire) begin
               status_in = STATUS_OK;
               pos_in    = '0;
               state_in  = STATE_RESP;
               unique case (req_bus.operation)
                  OP_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_req.en = 1'b1;
                        count_in  = count_ff + CNT_BITS'(1);
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_req.en   = 1'b1;
                        wr_req.addr = slot_dec(front_ff);
                        front_in    = slot_dec(front_ff);
                        count_in    = count_ff + CNT_BITS'(1);
                     end
                  end
                  OP_POP_BACK: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_BITS'(1);
                     end
                  end
                  OP_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        front_in = slot_inc(front_ff);
                        count_in = count_ff - CNT_BITS'(1);
                     end
                  end
                  OP_FIND: begin
                     key_in     = req_word;
                     rd_addr_in = front_ff;
                     rd_idx_in  = '0;
                     if (is_empty) begin
                        status_in = STATUS_NOT_FOUND;
                     end else begin
                        state_in = STATE_SCAN;
                     end
                  end
                  default: begin
                     status_in = STATUS_OK;
                  end
               endcase
            end
         end
         STATE_SCAN: begin
            // Issue one read per cycle while words remain.
            if (rd_idx_ff < count_ff) begin
               rd_req.en  = 1'b1;
               rd_addr_in = slot_inc(rd_addr_ff);
               rd_idx_in  = rd_idx_ff + CNT_BITS'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[PTR_BITS-1:0];
            end
            // Check the word read in the previous cycle.
            if (cmp_vld_ff) begin
               if (rd_data == key_ff) begin
                  status_in  = STATUS_OK;
                  pos_in     = cmp_idx_ff;
                  cmp_vld_in = 1'b0;
                  state_in   = STATE_RESP;
               end else if (CNT_BITS'(cmp_idx_ff) + CNT_BITS'(1) == count_ff) begin
                  status_in  = STATUS_NOT_FOUND;
                  pos_in     = '0;
                  cmp_vld_in = 1'b0;
                  state_in   = STATE_RESP;
               end
            end
         end
         STATE_RESP: begin
            rsp_bus.valid = 1'b1;
            if (rsp_bus.ready) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // Response beat fields.
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.found_position = POS_BITS'(pos_ff);
   assign rsp_bus.occupancy      = OCC_BITS'(count_ff);

   // The count never exceeds the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("word count above queue depth");

   // Requests and responses are never offered in the same cycle.
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request ready while a response is pending");

   // A full status is only reported with a full queue.
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && status_ff == STATUS_FULL |-> count_ff == CNT_BITS'(QUEUE_DEPTH))
      else $error("full status with room left");

   // An empty status is only reported with an empty queue.
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && status_ff == STATUS_EMPTY |-> count_ff == '0)
      else $error("empty status with words held");

   // A found word lies inside the held range.
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) && $past(state_ff) == STATE_SCAN && status_ff == STATUS_OK
      |-> CNT_BITS'(pos_ff) < count_ff)
      else $error("found position beyond held words");

endmodule

/* bench/dqs_response_checker.sv */
module dqs_response_checker import dqs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dqs_req_if          req_mon,
   dqs_rsp_if          rsp_mon,
   output int unsigned pending_results,
   output int unsigned fail_count,
   output int unsigned checked_results,
   output int unsigned full_seen,
   output int unsigned empty_seen,
   output int unsigned miss_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type          status;
      logic [POS_BITS-1:0] position;
      logic [OCC_BITS-1:0] occupancy;
   } deque_result_type;

   // Shadow copy of the queue contents: circular store, front slot and word count.
   word_type word_mem [QUEUE_DEPTH];
   int       head_slot;
   int       words_held;

   // Results owed by the block, oldest first.
   deque_result_type awaited_results [$];
   deque_result_type oldest_result;

   // Applies one operation to the shadow queue and returns the result it should give.
   function automatic deque_result_type apply_deque_op(input logic [OP_BITS-1:0] op,
                                                       input word_type key);
      deque_result_type res;
      int               slot;
      bit               hit;
      res.status   = STATUS_OK;
      res.position = '0;
      hit          = 1'b0;
      case (op)
         OP_PUSH_BACK: begin
            if (words_held >= QUEUE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               word_mem[(head_slot + words_held) % QUEUE_DEPTH] = key;
               words_held++;
            end
         end
         OP_PUSH_FRONT: begin
            if (words_held >= QUEUE_DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               head_slot = (head_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
               word_mem[head_slot] = key;
               words_held++;
            end
         end
         OP_POP_BACK: begin
            if (words_held == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               words_held--;
            end
         end
         OP_POP_FRONT: begin
            if (words_held == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               head_slot = (head_slot + 1) % QUEUE_DEPTH;
               words_held--;
            end
         end
         OP_FIND: begin
            // Scan from the front; the first equal word wins.
            res.status = STATUS_NOT_FOUND;
            for (int i = 0; i < words_held; i++) begin
               slot = (head_slot + i) % QUEUE_DEPTH;
               if (!hit && word_mem[slot] == key) begin
                  hit          = 1'b1;
                  res.status   = STATUS_OK;
                  res.position = POS_BITS'(i);
               end
            end
         end
         default: begin
            // Spare operation codes leave the queue alone.
         end
      endcase
      res.occupancy = OCC_BITS'(words_held);
      return res;
   endfunction

   function automatic void compare_field(input string field, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   // Response beats are checked before the request beat of the same edge is predicted,
   // so a response can never be matched against a request taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         head_slot  = 0;
         words_held = 0;
         awaited_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected response beat, expected none, actual status %0d",
                        $time, rsp_mon.status);
            end else begin
               oldest_result = awaited_results.pop_front();
               compare_field("status", oldest_result.status, rsp_mon.status);
               compare_field("found_position", oldest_result.position, rsp_mon.found_position);
               compare_field("occupancy", oldest_result.occupancy, rsp_mon.occupancy);
               checked_results++;
            end
            case (rsp_mon.status)
               STATUS_FULL:      full_seen++;
               STATUS_EMPTY:     empty_seen++;
               STATUS_NOT_FOUND: miss_seen++;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            awaited_results.push_back(apply_deque_op(req_mon.operation, req_mon.value));
         end
      end
      pending_results = awaited_results.size();
   end

endmodule

/* bench/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import dqs_pkg::*;

   localparam int unsigned ITEM_TARGET   = 1850;
   localparam int unsigned QUIET_TAIL    = 200;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int          POOL_SIZE     = 8;

   // Operation codes the block does not define; it must ignore them.
   localparam logic [OP_BITS-1:0] SPARE_OP_FIRST = 3'd5;
   localparam logic [OP_BITS-1:0] SPARE_OP_LAST  = 3'd7;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dqs_req_if req_bus ();
   dqs_rsp_if rsp_bus ();

   int unsigned pending_results;
   int unsigned fail_count;
   int unsigned checked_results;
   int unsigned full_seen;
   int unsigned empty_seen;
   int unsigned miss_seen;

   int unsigned cycle_count = 0;
   int unsigned sent_beats  = 0;
   int unsigned push_beats  = 0;
   int unsigned pop_beats   = 0;
   int unsigned find_beats  = 0;
   int unsigned spare_beats = 0;
   bit          quiet_tail  = 1'b0;
   bit          gaps_enabled;
   word_type    key_pool [POOL_SIZE];

   double_ended_queue_with_search u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   dqs_response_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .pending_results (pending_results),
      .fail_count      (fail_count),
      .checked_results (checked_results),
      .full_seen       (full_seen),
      .empty_seen      (empty_seen),
      .miss_seen       (miss_seen)
   );

   always #6 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: run timed out after %0d cycles", cycle_count);
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Drives one request beat and returns at the falling edge after it is taken.
   // Valid stays high so that a back-to-back beat needs no second assignment.
   task automatic send_request(input logic [OP_BITS-1:0] op, input word_type val);
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.value     <= val;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      sent_beats++;
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: push_beats++;
         OP_POP_BACK, OP_POP_FRONT:   pop_beats++;
         OP_FIND:                     find_beats++;
         default:                     spare_beats++;
      endcase
   endtask

   // Random gap on the request side.
   task automatic sender_pause();
      if (!quiet_tail && gaps_enabled && $urandom_range(3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
   endtask

   task automatic directed_request(input logic [OP_BITS-1:0] op, input word_type val);
      send_request(op, val);
      sender_pause();
   endtask

   // Operation mix: fill phases push hard so the queue reaches full, drain phases
   // empty it, and finds and spare codes are sprinkled through all of them.
   function automatic logic [OP_BITS-1:0] pick_operation(input mix_type mix);
      int roll;
      int push_share;
      roll = $urandom_range(99);
      if (roll < 3) begin
         return OP_BITS'($urandom_range(SPARE_OP_FIRST, SPARE_OP_LAST));
      end
      if (roll < 25) begin
         return OP_FIND;
      end
      case (mix)
         MIX_FILL:  push_share = 80;
         MIX_DRAIN: push_share = 20;
         default:   push_share = 50;
      endcase
      if ($urandom_range(99) < push_share) begin
         return ($urandom_range(1) == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end
      return ($urandom_range(1) == 0) ? OP_POP_BACK : OP_POP_FRONT;
   endfunction

   // Half of the values, and most find keys, come from a small pool so that finds hit and duplicates occur.
   function automatic word_type pick_value(input logic [OP_BITS-1:0] op);
      int roll;
      roll = $urandom_range(99);
      if (roll < ((op == OP_FIND) ? 70 : 50)) begin
         return key_pool[$urandom_range(POOL_SIZE - 1)];
      end
      return word_type'($urandom);
   endfunction

   task automatic refresh_key_pool();
      key_pool[0] = 32'sh7FFF_FFFF;
      key_pool[1] = 32'sh8000_0000;
      key_pool[2] = word_type'($urandom_range(3));
      for (int i = 3; i < POOL_SIZE; i++) begin
         key_pool[i] = word_type'($urandom);
      end
   endtask

   // Response side: ready drops in random bursts, none in the quiet tail.
   initial begin
      rsp_bus.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   // Request side and verdict.
   initial begin
      mix_type     mix;
      int unsigned seg_len;
      int unsigned segment;
      logic [OP_BITS-1:0] op;

      req_bus.valid     = 1'b0;
      req_bus.operation = OP_PUSH_BACK;
      req_bus.value     = '0;
      gaps_enabled      = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty queue: both pops and a find.
      directed_request(OP_POP_BACK, 32'sd0);
      directed_request(OP_POP_FRONT, 32'sd0);
      directed_request(OP_FIND, 32'sd0);
      // Extreme words at both ends, then searches for each and for a missing key.
      directed_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
      directed_request(OP_PUSH_FRONT, 32'sh8000_0000);
      directed_request(OP_FIND, 32'sh8000_0000);
      directed_request(OP_FIND, 32'sh7FFF_FFFF);
      directed_request(OP_FIND, 32'sd0);
      // Spare codes change nothing.
      directed_request(SPARE_OP_FIRST, 32'sh7FFF_FFFF);
      directed_request(SPARE_OP_FIRST + 3'd1, -32'sd1);
      directed_request(SPARE_OP_LAST, 32'sh8000_0000);
      // Pops down to empty, the last word leaving through each end.
      directed_request(OP_POP_BACK, 32'sd0);
      directed_request(OP_POP_FRONT, 32'sd0);
      directed_request(OP_PUSH_FRONT, -32'sd1);
      directed_request(OP_FIND, -32'sd1);
      directed_request(OP_POP_FRONT, 32'sd0);
      directed_request(OP_PUSH_BACK, 32'sd0);
      directed_request(OP_POP_BACK, 32'sd0);
      directed_request(OP_FIND, 32'sd0);

      // Random phases of filling, draining and mixed traffic.
      segment = 0;
      while (sent_beats < ITEM_TARGET) begin
         mix          = mix_type'($urandom_range(2));
         seg_len      = $urandom_range(20, 60);
         gaps_enabled = ($urandom_range(2) != 0);
         refresh_key_pool();
         quiet_tail   = (sent_beats >= ITEM_TARGET - QUIET_TAIL);
         // Hold off now and then until every owed response has come back.
         if (!quiet_tail && (segment == 3 || $urandom_range(4) == 0)) begin
            req_bus.valid <= 1'b0;
            do @(negedge clock); while (pending_results != 0);
         end
         for (int k = 0; k < seg_len && sent_beats < ITEM_TARGET; k++) begin
            quiet_tail = (sent_beats >= ITEM_TARGET - QUIET_TAIL);
            op = pick_operation(mix);
            send_request(op, pick_value(op));
            sender_pause();
         end
         segment++;
      end

      // Drain: wait for every response, then a little longer for strays.
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("tb_top: %0d request beats (%0d pushes, %0d pops, %0d finds, %0d spare codes)",
               sent_beats, push_beats, pop_beats, find_beats, spare_beats);
      $display("tb_top: %0d responses checked, %0d full, %0d empty, %0d not found, %0d errors",
               checked_results, full_seen, empty_seen, miss_seen, fail_count);
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
